// ===== rtl/iee_pkg.sv =====
package iee_pkg;

   localparam int unsigned DATA_W   = 32;
   localparam int unsigned DIV_CNT_W = $clog2(DATA_W);

   localparam logic [7:0] CH_NEWLINE = 8'd10;
   localparam logic [7:0] CH_SPACE   = 8'd32;
   localparam logic [7:0] CH_STAR    = 8'd42;
   localparam logic [7:0] CH_PLUS    = 8'd43;
   localparam logic [7:0] CH_MINUS   = 8'd45;
   localparam logic [7:0] CH_SLASH   = 8'd47;
   localparam logic [7:0] CH_ZERO    = 8'd48;
   localparam logic [7:0] CH_NINE    = 8'd57;

   typedef enum logic [1:0] {
      OP_LOAD = 2'd0,
      OP_MUL  = 2'd1,
      OP_DIV  = 2'd2
   } term_op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_INVALID = 2'd1,
      ST_DIVZERO = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      CC_DIGIT,
      CC_SPACE,
      CC_ADDSUB,
      CC_MULDIV,
      CC_NEWLINE,
      CC_INVALID
   } char_class_type;

   typedef enum logic [1:0] {
      CK_SUM,
      CK_TERM,
      CK_END
   } close_kind_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_CLOSE,
      S_DIVIDE,
      S_APPLY
   } state_type;

   function automatic char_class_type classify(input logic [7:0] c);
      char_class_type cls;
      if (c >= CH_ZERO && c <= CH_NINE) cls = CC_DIGIT;
      else if (c == CH_SPACE) cls = CC_SPACE;
      else if (c == CH_PLUS || c == CH_MINUS) cls = CC_ADDSUB;
      else if (c == CH_STAR || c == CH_SLASH) cls = CC_MULDIV;
      else if (c == CH_NEWLINE) cls = CC_NEWLINE;
      else cls = CC_INVALID;
      return cls;
   endfunction

endpackage

// ===== rtl/iee_divider.sv =====
module iee_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [iee_pkg::DATA_W-1:0]   dividend,
   input  logic [iee_pkg::DATA_W-1:0]   divisor,
   output logic                         done,
   output logic [iee_pkg::DATA_W-1:0]   quotient
);
   import iee_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 neg_ff, neg_in;
   logic [DATA_W-1:0]    rem_ff, rem_in;
   logic [DATA_W-1:0]    quo_ff, quo_in;
   logic [DATA_W-1:0]    div_ff, div_in;
   logic [DATA_W:0]      diff;

   // one restoring step per cycle on magnitudes
   assign diff = {rem_ff, quo_ff[DATA_W-1]} - {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         neg_in  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
         rem_in  = '0;
         quo_in  = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
         div_in  = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
      end else if (busy_ff) begin
         rem_in = diff[DATA_W] ? {rem_ff[DATA_W-2:0], quo_ff[DATA_W-1]} : diff[DATA_W-1:0];
         quo_in = {quo_ff[DATA_W-2:0], ~diff[DATA_W]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == '1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (~quo_ff + 1'b1) : quo_ff;

endmodule

// ===== rtl/infix_expression_evaluator_unit.sv =====
// Channel  Dir  Ports                 Payload
// req      in   req_tvalid/tready     tdata[7:0] char_code, tlast last
// rsp      out  rsp_tvalid/tready     tdata[31:0] value, tuser[1:0] status
//
// A digit, space or invalid character is decoded only; + - * / is also
// closed and applied. Closing a nonzero divisor runs the shared 32-step divider.
// An expression end adds a close and apply (and a divide for a divisor); an
// operator flagged last closes twice. Synchronous active-high reset clears the
// control state, accumulators and output valid. The result waits in an output
// register while the next expression starts; only the next result stalls on it.
module infix_expression_evaluator_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [7:0]                  req_tdata,  // [7:0] char_code
   input  logic                        req_tlast,  // last
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic signed [31:0]          rsp_tdata,  // [31:0] value
   output logic [1:0]                  rsp_tuser   // [1:0] status
);
   import iee_pkg::*;

   state_type         state_ff, state_in;
   close_kind_type    kind_ff, kind_in;
   logic [7:0]        char_ff, char_in;
   logic              end_ff, end_in;
   logic [DATA_W-1:0] sum_ff, sum_in;
   logic [DATA_W-1:0] term_ff, term_in;
   logic [DATA_W-1:0] num_ff, num_in;
   term_op_type       op_ff, op_in;
   logic              sign_ff, sign_in;
   status_type        err_ff, err_in;
   logic [DATA_W-1:0] factor_ff, factor_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   status_type        rsp_status_ff, rsp_status_in;

   char_class_type    cls;
   logic              out_free;
   logic              div_start;
   logic              div_done;
   logic [DATA_W-1:0] div_quotient;
   logic [DATA_W-1:0] product;
   logic [DATA_W-1:0] total;
   logic [7:0]        digit;

   assign cls      = classify(char_ff);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign product  = term_ff * num_ff;
   assign total    = sign_ff ? (sum_ff - factor_ff) : (sum_ff + factor_ff);
   assign digit    = char_ff - CH_ZERO;

   iee_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (term_ff),
      .divisor  (num_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_DECODE;
         end
         S_DECODE: begin
            if (cls == CC_ADDSUB || cls == CC_MULDIV || end_ff) state_in = S_CLOSE;
            else state_in = S_IDLE;
         end
         S_CLOSE: begin
            if (op_ff == OP_DIV && num_ff != '0) state_in = S_DIVIDE;
            else state_in = S_APPLY;
         end
         S_DIVIDE: begin
            if (div_done) state_in = S_APPLY;
         end
         S_APPLY: begin
            if (kind_ff == CK_END) begin
               if (out_free) state_in = S_IDLE;
            end else begin
               state_in = end_ff ? S_CLOSE : S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_tready = 1'b0;
      div_start  = 1'b0;
      unique case (state_ff)
         S_IDLE:  req_tready = 1'b1;
         S_CLOSE: div_start  = (op_ff == OP_DIV) && (num_ff != '0);
         default: ;
      endcase
   end

   // datapath
   always_comb begin
      kind_in       = kind_ff;
      char_in       = char_ff;
      end_in        = end_ff;
      sum_in        = sum_ff;
      term_in       = term_ff;
      num_in        = num_ff;
      op_in         = op_ff;
      sign_in       = sign_ff;
      err_in        = err_ff;
      factor_in     = factor_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      unique case (state_ff)
         S_IDLE: begin
            char_in = req_tdata;
            end_in  = req_tlast || (req_tdata == CH_NEWLINE);
         end
         S_DECODE: begin
            unique case (cls)
               CC_DIGIT:   num_in = (num_ff << 3) + (num_ff << 1) + {24'd0, digit};
               CC_INVALID: err_in = ST_INVALID;
               default: ;
            endcase
            unique case (cls)
               CC_ADDSUB: kind_in = CK_SUM;
               CC_MULDIV: kind_in = CK_TERM;
               default:   kind_in = CK_END;
            endcase
         end
         S_CLOSE: begin
            unique case (op_ff)
               OP_MUL: factor_in = product;
               OP_DIV: begin
                  factor_in = '0;
                  if (num_ff == '0 && err_ff == ST_OK) err_in = ST_DIVZERO;
               end
               default: factor_in = num_ff;
            endcase
         end
         S_DIVIDE: begin
            if (div_done) factor_in = div_quotient;
         end
         S_APPLY: begin
            unique case (kind_ff)
               CK_SUM: begin
                  sum_in  = total;
                  term_in = '0;
                  op_in   = OP_LOAD;
                  sign_in = (char_ff == CH_MINUS);
                  num_in  = '0;
                  kind_in = CK_END;
               end
               CK_TERM: begin
                  term_in = factor_ff;
                  op_in   = (char_ff == CH_STAR) ? OP_MUL : OP_DIV;
                  num_in  = '0;
                  kind_in = CK_END;
               end
               default: begin
                  // hold until the output register frees up
                  if (out_free) begin
                     rsp_valid_in  = 1'b1;
                     rsp_value_in  = (err_ff == ST_OK) ? total : '0;
                     rsp_status_in = err_ff;
                     sum_in        = '0;
                     term_in       = '0;
                     num_in        = '0;
                     op_in         = OP_LOAD;
                     sign_in       = 1'b0;
                     err_in        = ST_OK;
                  end
               end
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         kind_ff      <= CK_END;
         end_ff       <= 1'b0;
         sum_ff       <= '0;
         term_ff      <= '0;
         num_ff       <= '0;
         op_ff        <= OP_LOAD;
         sign_ff      <= 1'b0;
         err_ff       <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         end_ff       <= end_in;
         sum_ff       <= sum_in;
         term_ff      <= term_in;
         num_ff       <= num_in;
         op_ff        <= op_in;
         sign_ff      <= sign_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      char_ff       <= char_in;
      factor_ff     <= factor_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

// ===== rtl/iee_checker.sv =====
module iee_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_tvalid,
   input logic               req_tready,
   input logic               rsp_tvalid,
   input logic               rsp_tready,
   input logic signed [31:0] rsp_tdata,
   input logic [1:0]         rsp_tuser
);
   import iee_pkg::*;

   // a stalled transaction holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp payload changed while stalled");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_OK |-> rsp_tdata == 0)
      else $error("value not zero on error status");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser == ST_OK || rsp_tuser == ST_INVALID || rsp_tuser == ST_DIVZERO)
      else $error("unknown status code");

   // every accepted character passes through decode before ready returns
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready right after a transaction");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind infix_expression_evaluator_unit iee_checker u_iee_checker (.*);

// ===== test/tb_infix_expression_evaluator_unit.sv =====
module tb_infix_expression_evaluator_unit;
   import iee_pkg::*;

   localparam int unsigned CYCLE_LIMIT     = 600000;
   localparam int unsigned ITEMS_PER_PHASE = 350;
   localparam int unsigned DRAIN_CYCLES    = 100;

   // Tracks the evaluator state and holds the results still owed by the block.
   class expr_scoreboard;
      typedef struct packed {
         logic [31:0] value;
         status_type  status;
      } expr_result_type;

      expr_result_type pending[$];
      logic [31:0]  sum_acc;
      logic [31:0]  term_acc;
      logic [31:0]  num_acc;
      term_op_type  term_op;
      logic         subtract;
      status_type   latched_status;
      int           errors;

      function new();
         errors = 0;
         clear();
      endfunction

      function void clear();
         sum_acc        = '0;
         term_acc       = '0;
         num_acc        = '0;
         term_op        = OP_LOAD;
         subtract       = 1'b0;
         latched_status = ST_OK;
      endfunction

      // Fold the number being read into the running term.
      function logic [31:0] close_factor();
         logic [31:0] mag_a;
         logic [31:0] mag_b;
         logic [31:0] quot;
         logic [31:0] res;
         case (term_op)
            OP_MUL: res = term_acc * num_acc;
            OP_DIV: begin
               if (num_acc == '0) begin
                  if (latched_status == ST_OK) latched_status = ST_DIVZERO;
                  res = '0;
               end else begin
                  mag_a = term_acc[31] ? -term_acc : term_acc;
                  mag_b = num_acc[31] ? -num_acc : num_acc;
                  quot  = mag_a / mag_b;
                  res   = (term_acc[31] != num_acc[31]) ? -quot : quot;
               end
            end
            default: res = num_acc;
         endcase
         return res;
      endfunction

      function logic [31:0] add_term(logic [31:0] t);
         return subtract ? sum_acc - t : sum_acc + t;
      endfunction

      function void note_char(logic [7:0] code, logic is_last);
         expr_result_type exp_res;
         logic [31:0]  total;
         logic         done;
         done = is_last;
         if (code == CH_NEWLINE) begin
            done = 1'b1;
         end else if (code == CH_SPACE) begin
            // skip
         end else if (code >= CH_ZERO && code <= CH_NINE) begin
            num_acc = num_acc * 32'd10 + 32'(code - CH_ZERO);
         end else if (code == CH_PLUS || code == CH_MINUS) begin
            sum_acc  = add_term(close_factor());
            term_acc = '0;
            term_op  = OP_LOAD;
            subtract = (code == CH_MINUS);
            num_acc  = '0;
         end else if (code == CH_STAR || code == CH_SLASH) begin
            term_acc = close_factor();
            term_op  = (code == CH_STAR) ? OP_MUL : OP_DIV;
            num_acc  = '0;
         end else begin
            latched_status = ST_INVALID;
         end
         if (done) begin
            total          = add_term(close_factor());
            exp_res.status = latched_status;
            exp_res.value  = (latched_status == ST_OK) ? total : '0;
            pending.push_back(exp_res);
            clear();
         end
      endfunction

      function void check_result(logic [31:0] value, logic [1:0] status);
         expr_result_type exp_res;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual value %0d status %0d",
                     $time, $signed(value), status);
            errors++;
            return;
         end
         exp_res = pending.pop_front();
         if (value !== exp_res.value) begin
            $display("%0t: value mismatch: expected %0d, actual %0d",
                     $time, $signed(exp_res.value), $signed(value));
            errors++;
         end
         if (status !== exp_res.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, exp_res.status, status);
            errors++;
         end
      endfunction
   endclass

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [7:0]         req_tdata  = '0;
   logic               req_tlast  = 1'b0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic signed [31:0] rsp_tdata;
   logic [1:0]         rsp_tuser;

   expr_scoreboard sb;
   int unsigned    send_idle_pct = 0;
   int unsigned    recv_stall_pct = 0;
   int unsigned    chars_sent = 0;
   int unsigned    cycle_count = 0;

   infix_expression_evaluator_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, sb.pending.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   // Hold the character until the transaction completes; keep valid high into
   // the next character unless the sender idles.
   task automatic send_char(input logic [7:0] code, input logic is_last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= code;
      req_tlast  <= is_last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_char(code, is_last);
      chars_sent++;
   endtask

   task automatic send_text(input string text, input logic last_on_final);
      for (int i = 0; i < text.len(); i++) begin
         send_char(text[i], last_on_final && (i == text.len() - 1));
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending.size() != 0);
   endtask

   task automatic send_random_expr();
      logic [7:0]  chars[$];
      logic [7:0]  ops[4];
      logic [31:0] specials[5];
      string       digits;
      int          n_operands;
      int          end_mode;
      ops      = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
      specials = '{32'd0, 32'd1, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff};
      n_operands = $urandom_range(6, 1);
      if ($urandom_range(99) < 8) begin
         // broken input: raw bytes
         repeat ($urandom_range(8, 1)) chars.push_back(8'($urandom_range(255)));
      end else begin
         if ($urandom_range(99) < 5) chars.push_back(ops[$urandom_range(3)]);
         for (int k = 0; k < n_operands; k++) begin
            if (k > 0) chars.push_back(ops[$urandom_range(3)]);
            if ($urandom_range(99) < 12) chars.push_back(CH_SPACE);
            digits = "";
            case ($urandom_range(9))
               0: digits = "";
               1, 2: digits = $sformatf("%0d", specials[$urandom_range(4)]);
               3: repeat ($urandom_range(12, 1))
                     digits = {digits, $sformatf("%0d", $urandom_range(9))};
               default: repeat ($urandom_range(3, 1))
                     digits = {digits, $sformatf("%0d", $urandom_range(9))};
            endcase
            for (int i = 0; i < digits.len(); i++) chars.push_back(digits[i]);
            if ($urandom_range(99) < 12) chars.push_back(CH_SPACE);
            if ($urandom_range(99) < 3) chars.push_back(8'($urandom_range(255)));
         end
      end
      end_mode = $urandom_range(2);
      if (end_mode < 2 || chars.size() == 0) chars.push_back(CH_NEWLINE);
      for (int i = 0; i < chars.size(); i++) begin
         send_char(chars[i], (end_mode != 0) && (i == chars.size() - 1));
      end
   endtask

   initial begin
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_text("\n", 1'b0);
      send_text("7/0\n", 1'b0);
      send_text("1/0", 1'b0);
      send_char(8'd255, 1'b1);
      send_text("- 5+1\n", 1'b1);
      send_text("9", 1'b1);
      send_text("3*4-8//2\n", 1'b0);
      send_char(8'd0, 1'b0);
      send_text("\n", 1'b0);
      wait_drained();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
            default: begin send_idle_pct = 15; recv_stall_pct = 15; end
         endcase
         // hold off until the block has returned every result
         if (phase == 2) wait_drained();
         while (chars_sent < (phase + 1) * ITEMS_PER_PHASE) send_random_expr();
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/iee_pkg.sv
rtl/iee_divider.sv
rtl/infix_expression_evaluator_unit.sv
rtl/iee_checker.sv
test/tb_infix_expression_evaluator_unit.sv
